/* hdl/esp_pkg.sv */
// Package for the endpoint string parser: payload structs, scope codes,
// recognizer phase codes and character helpers. No dependencies.
package esp_pkg;

  localparam int MaxChars = 1024;
  localparam int PosW = 11;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } esp_in_t;

  typedef struct packed {
    logic [2:0]      scope;
    logic [31:0]     ip4_address;
    logic [63:0]     ip6_high;
    logic [63:0]     ip6_low;
    logic [PosW-1:0] name_offset;
    logic [PosW-1:0] name_length;
    logic [15:0]     port;
    logic            port_found;
    logic            too_long;
  } esp_out_t;

  localparam logic [2:0] ScopeNull    = 3'd0;
  localparam logic [2:0] ScopeIp4     = 3'd1;
  localparam logic [2:0] ScopeIp6     = 3'd2;
  localparam logic [2:0] ScopeName    = 3'd3;
  localparam logic [2:0] ScopeIp4Name = 3'd4;
  localparam logic [2:0] ScopeIp6Name = 3'd5;
  localparam logic [2:0] ScopeIpc     = 3'd6;

  typedef enum logic [2:0] {
    TR_OFF, TR_FRESH, TR_NAME, TR_COLON, TR_DIGITS, TR_DONE
  } tr_phase_t;

  typedef enum logic [1:0] {V4_ACTIVE, V4_OK, V4_FAIL} v4_mode_t;

  localparam logic [5:0] V6Done = 6'd41;
  localparam logic [5:0] V6Fail = 6'd63;

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

/* hdl/endpoint_string_parser_core.sv */
// Endpoint string parser one byte per cycle: prefix, IPv4 / IPv6 recognizers
// and three name/port trackers updated in parallel. Uses esp_pkg.
// Rate: one byte per cycle, back to back, while no held result stalls input;
// the result of the last byte is registered in out_data and shows in the
// cycle after acceptance.
module endpoint_string_parser_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  esp_pkg::esp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output esp_pkg::esp_out_t out_data
);
  import esp_pkg::*;

  typedef struct packed {
    tr_phase_t       phase;
    logic [PosW-1:0] start;
    logic [PosW-1:0] len;
    logic            empty;
    logic [32:0]     value;
    logic            ok;
  } track_t;

  logic [PosW-1:0] position, position_next;
  logic [2:0]      pstate, pstate_next;
  logic [2:0]      allow, allow_next;
  v4_mode_t        v4_mode, v4_mode_next;
  logic [1:0]      v4_octet, v4_octet_next;
  logic [1:0]      v4_digits, v4_digits_next;
  logic [9:0]      v4_value, v4_value_next;
  logic [31:0]     v4_octets, v4_octets_next;
  logic [5:0]      v6_prog, v6_prog_next;
  logic [15:0]     v6_groups [8];
  logic [15:0]     v6_groups_next [8];
  track_t          tracks [3];
  track_t          tracks_next [3];
  esp_out_t        res_next;

  logic            accept;
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  function automatic track_t track_init(tr_phase_t ph);
    track_t t;
    t = '0;
    t.phase = ph;
    return t;
  endfunction

  // group index in the low bits, separator slot in the top bit
  function automatic logic [3:0] v6_slot(logic [5:0] n);
    logic [3:0] s;
    s = '0;
    for (int k = 0; k < 8; k++) begin
      if (n > 6'(5 * k) && n <= 6'(5 * k + 5)) s = {n == 6'(5 * k + 5), 3'(k)};
    end
    return s;
  endfunction

  function automatic track_t track_feed(track_t t, logic [7:0] c, logic [PosW-1:0] pos);
    track_t     n;
    logic [36:0] v;
    n = t;
    v = {4'd0, t.value} * 37'd10 + {33'd0, c[3:0]};
    unique case (t.phase)
      TR_FRESH: begin
        if (c == ":") begin
          n.empty = 1'b1;
          n.phase = TR_COLON;
        end else begin
          n.start = pos;
          n.len   = PosW'(1);
          n.phase = TR_NAME;
        end
      end
      TR_NAME: begin
        if (c == ":") n.phase = TR_COLON;
        else if (t.len < PosW'(MaxChars)) n.len = t.len + 1'b1;
      end
      TR_COLON: begin
        if (is_digit(c)) begin
          n.value = {29'd0, c[3:0]};
          n.phase = TR_DIGITS;
        end else n.phase = TR_DONE;
      end
      TR_DIGITS: begin
        if (is_digit(c)) begin
          if (v > 37'hFFFFFFFF) begin
            n.ok    = 1'b0;
            n.phase = TR_DONE;
          end else n.value = v[32:0];
        end else begin
          n.ok    = 1'b1;
          n.phase = TR_DONE;
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  always_comb begin
    logic [7:0]      c;
    logic [1:0]      r4;
    logic [9:0]      nv;
    logic [4:0]      h;
    logic [3:0]      slot;
    logic [2:0]      g;
    logic [2:0]      kind;
    logic [2:0]      fa;
    logic [7:0]      expc;
    logic [2:0]      plen;
    logic            pdone;
    logic [PosW-1:0] pclamp, len;
    logic            is4, is6;
    logic [31:0]     a4;
    logic [1:0]      t;
    track_t          tr;
    c = in_data.ch;
    r4 = 2'd0;
    nv = v4_value * 10'd10 + {6'd0, c[3:0]};
    h = hex_value(c);
    slot = v6_slot(v6_prog);
    g = slot[2:0];
    pclamp = (position > PosW'(MaxChars)) ? PosW'(MaxChars) : position;

    position_next  = position;
    pstate_next    = pstate;
    allow_next     = allow;
    v4_mode_next   = v4_mode;
    v4_octet_next  = v4_octet;
    v4_digits_next = v4_digits;
    v4_value_next  = v4_value;
    v4_octets_next = v4_octets;
    v6_prog_next   = v6_prog;
    v6_groups_next = v6_groups;
    tracks_next    = tracks;
    res_next       = '0;
    kind = 3'd0; fa = 3'd0; expc = 8'd0; plen = 3'd0; pdone = 1'b0;
    is4 = 1'b0; is6 = 1'b0; a4 = '0; t = 2'd0; tr = '0; len = '0;

    // ipv4
    if (v4_mode == V4_ACTIVE) begin
      if (is_digit(c)) begin
        if (v4_digits == 2'd3) v4_mode_next = V4_FAIL;
        else begin
          v4_value_next  = nv;
          v4_digits_next = v4_digits + 1'b1;
          if (v4_digits == 2'd2 && v4_octet == 2'd3) begin
            if (nv > 10'd255) v4_mode_next = V4_FAIL;
            else begin
              v4_octets_next = {v4_octets[23:0], nv[7:0]};
              v4_mode_next = V4_OK;
              r4 = 2'd2;
            end
          end
        end
      end else if (c == "." && v4_digits != 2'd0 && v4_octet != 2'd3) begin
        if (v4_value > 10'd255) v4_mode_next = V4_FAIL;
        else begin
          v4_octets_next = {v4_octets[23:0], v4_value[7:0]};
          v4_octet_next  = v4_octet + 1'b1;
          v4_digits_next = '0;
          v4_value_next  = '0;
        end
      end else if (v4_digits != 2'd0 && v4_octet == 2'd3) begin
        if (v4_value > 10'd255) v4_mode_next = V4_FAIL;
        else begin
          v4_octets_next = {v4_octets[23:0], v4_value[7:0]};
          v4_mode_next = V4_OK;
          r4 = 2'd1;
        end
      end else v4_mode_next = V4_FAIL;
    end

    // trackers
    if (r4 == 2'd1) tracks_next[1] = track_init(TR_FRESH);
    for (int i = 0; i < 3; i++) tracks_next[i] = track_feed(tracks_next[i], c, pclamp);
    if (r4 == 2'd2) tracks_next[1] = track_init(TR_FRESH);

    // ipv6
    if (v6_prog < V6Done) begin
      if (v6_prog == 6'd0) v6_prog_next = (c == "[") ? 6'd1 : V6Fail;
      else if (v6_prog == 6'd40) begin
        if (c == "]") begin
          v6_prog_next = V6Done;
          tracks_next[2] = track_init(TR_FRESH);
        end else v6_prog_next = V6Fail;
      end else if (slot[3]) begin
        v6_prog_next = (c == ":") ? v6_prog + 1'b1 : V6Fail;
      end else if (h[4]) v6_prog_next = V6Fail;
      else begin
        v6_groups_next[g] = {v6_groups[g][11:0], h[3:0]};
        v6_prog_next = v6_prog + 1'b1;
      end
    end

    // prefix
    if (pstate < 3'd6) begin
      if (pstate < 3'd2) begin
        if (c == ((pstate == 3'd0) ? "i" : "p")) pstate_next = pstate + 1'b1;
        else begin
          pstate_next = 3'd7;
          allow_next  = 3'd7;
        end
      end else begin
        fa = allow;
        if (pstate == 3'd2) begin
          if (c == "c") fa = 3'd4;
          else if (c == "6") fa = 3'd2;
          else if (c == "4") fa = 3'd1;
          else if (c == ":") fa = 3'd3;
          else fa = 3'd0;
        end
        kind = (fa == 3'd4) ? 3'd0 : (fa == 3'd2) ? 3'd1 : (fa == 3'd1) ? 3'd2 : 3'd3;
        plen = (kind == 3'd3) ? 3'd5 : 3'd6;
        if (kind == 3'd3) begin
          unique case (pstate)
            3'd2:    expc = ":";
            3'd3:    expc = "/";
            default: expc = "/";
          endcase
        end else begin
          unique case (pstate)
            3'd2:    expc = (kind == 3'd0) ? "c" : (kind == 3'd1) ? "6" : "4";
            3'd3:    expc = ":";
            default: expc = "/";
          endcase
        end
        if (fa == 3'd0 || c != expc) begin
          pstate_next = 3'd7;
          allow_next  = 3'd7;
        end else begin
          allow_next = fa;
          if (pstate + 3'd1 == plen) begin
            pstate_next = 3'd6;
            pdone = 1'b1;
          end else pstate_next = pstate + 1'b1;
        end
      end
    end
    if (pdone) begin
      v4_mode_next = V4_ACTIVE;
      v4_octet_next = '0; v4_digits_next = '0; v4_value_next = '0; v4_octets_next = '0;
      v6_prog_next = '0;
      for (int i = 0; i < 8; i++) v6_groups_next[i] = '0;
      tracks_next[0] = track_init(TR_FRESH);
      tracks_next[1] = track_init(TR_OFF);
      tracks_next[2] = track_init(TR_OFF);
    end
    if (position <= PosW'(MaxChars)) position_next = position + 1'b1;

    // result
    if (pstate_next < 3'd6) fa = 3'd7;
    else fa = allow_next;
    len = (position_next > PosW'(MaxChars)) ? PosW'(MaxChars) : position_next;
    if (fa[0]) begin
      if (v4_mode_next == V4_OK) begin
        is4 = 1'b1; a4 = v4_octets_next;
      end else if (v4_mode_next == V4_ACTIVE && v4_octet_next == 2'd3 &&
                   v4_digits_next != 2'd0 && v4_value_next <= 10'd255) begin
        is4 = 1'b1; a4 = {v4_octets_next[23:0], v4_value_next[7:0]};
      end
    end
    is6 = !is4 && fa[1] && v6_prog_next == V6Done;
    if (is6) begin
      res_next.scope = ScopeIp6; t = 2'd2;
    end else if (is4) begin
      res_next.scope = ScopeIp4; t = 2'd1;
    end else begin
      t = 2'd0;
      if (fa[1:0] == 2'b11) res_next.scope = ScopeName;
      else if (fa[1]) res_next.scope = ScopeIp6Name;
      else if (fa[0]) res_next.scope = ScopeIp4Name;
      else if (fa[2]) res_next.scope = ScopeIpc;
      else res_next.scope = ScopeNull;
    end
    tr = tracks_next[t];
    if (tr.phase == TR_OFF || tr.phase == TR_FRESH || tr.empty) begin
      res_next.name_offset = len;
    end else begin
      res_next.name_offset = tr.start;
      res_next.name_length = tr.len;
    end
    if (tr.phase == TR_DIGITS || (tr.phase == TR_DONE && tr.ok)) begin
      res_next.port_found = 1'b1;
      res_next.port = tr.value[15:0];
    end
    res_next.ip4_address = is4 ? a4 : '0;
    if (is6) begin
      res_next.ip6_high = {v6_groups_next[0], v6_groups_next[1],
                           v6_groups_next[2], v6_groups_next[3]};
      res_next.ip6_low  = {v6_groups_next[4], v6_groups_next[5],
                           v6_groups_next[6], v6_groups_next[7]};
    end
    res_next.too_long = position_next > PosW'(MaxChars);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_data.last)) begin
      position <= '0; pstate <= '0; allow <= '0;
      v4_mode <= V4_ACTIVE; v4_octet <= '0; v4_digits <= '0; v4_value <= '0;
      v4_octets <= '0; v6_prog <= '0;
      for (int i = 0; i < 8; i++) v6_groups[i] <= '0;
      tracks[0] <= track_init(TR_FRESH);
      tracks[1] <= track_init(TR_OFF);
      tracks[2] <= track_init(TR_OFF);
    end else if (accept) begin
      position <= position_next; pstate <= pstate_next; allow <= allow_next;
      v4_mode <= v4_mode_next; v4_octet <= v4_octet_next; v4_digits <= v4_digits_next;
      v4_value <= v4_value_next; v4_octets <= v4_octets_next; v6_prog <= v6_prog_next;
      v6_groups <= v6_groups_next;
      tracks <= tracks_next;
    end
    if (rst) out_valid <= 1'b0;
    else if (accept && in_data.last) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (accept && in_data.last) out_data <= res_next;
  end

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("input taken while result stalled");
  a_pos_sat: assert property (@(posedge clk) disable iff (rst)
    position <= PosW'(MaxChars + 1)) else $error("position past saturation");
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept && in_data.last)) else $error("spurious result");
  a_fresh_string: assert property (@(posedge clk) disable iff (rst)
    $past(accept && in_data.last) |-> position == '0) else $error("string state not cleared");
`endif

endmodule

/* tb/tb_endpoint_string_parser_core.sv */
// Testbench for endpoint_string_parser_core: streams endpoint strings byte by
// byte and checks every result against a built-in parser model.
// Depends on esp_pkg and the core RTL.
module tb_endpoint_string_parser_core;
  import esp_pkg::*;

  localparam int StallLimit = 20000;
  localparam int ItemTarget = 1300;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  esp_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  esp_out_t out_data;

  endpoint_string_parser_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // parser model state
  int unsigned  pos_cnt;
  int unsigned  pfx_st;
  bit [2:0]     allow;
  v4_mode_t     v4_mode;
  int unsigned  v4_oct, v4_dig, v4_val;
  bit [31:0]    v4_word;
  int unsigned  v6_st;
  bit [15:0]    v6_grp [8];
  tr_phase_t    trk_phase [3];
  int unsigned  trk_start [3], trk_len [3];
  bit           trk_empty [3];
  longint unsigned prt_val [3];
  bit           prt_ok [3];

  esp_in_t  byte_q [$];
  esp_out_t parse_q [$];
  int       mismatches;
  int       accepted_in;
  bit       stim_done;

  function automatic int unsigned clamp_len(int unsigned v);
    return v > MaxChars ? MaxChars : v;
  endfunction

  function automatic int hex_of(bit [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void track_set(int t, tr_phase_t ph);
    trk_phase[t] = ph;
    trk_start[t] = 0;
    trk_len[t] = 0;
    trk_empty[t] = 0;
    prt_val[t] = 0;
    prt_ok[t] = 0;
  endfunction

  function automatic void track_feed(int t, bit [7:0] c);
    bit dig;
    longint unsigned v;
    dig = c >= "0" && c <= "9";
    case (trk_phase[t])
      TR_FRESH: begin
        if (c == ":") begin
          trk_empty[t] = 1;
          trk_phase[t] = TR_COLON;
        end else begin
          trk_start[t] = clamp_len(pos_cnt);
          trk_len[t] = 1;
          trk_phase[t] = TR_NAME;
        end
      end
      TR_NAME: begin
        if (c == ":") trk_phase[t] = TR_COLON;
        else if (trk_len[t] < MaxChars) trk_len[t]++;
      end
      TR_COLON: begin
        if (dig) begin
          prt_val[t] = c - "0";
          trk_phase[t] = TR_DIGITS;
        end else trk_phase[t] = TR_DONE;
      end
      TR_DIGITS: begin
        if (dig) begin
          v = prt_val[t] * 10 + (c - "0");
          if (v > 64'hFFFF_FFFF) begin
            prt_ok[t] = 0;
            trk_phase[t] = TR_DONE;
          end else prt_val[t] = v;
        end else begin
          prt_ok[t] = 1;
          trk_phase[t] = TR_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void v4_restart();
    v4_mode = V4_ACTIVE;
    v4_oct = 0;
    v4_dig = 0;
    v4_val = 0;
    v4_word = 0;
  endfunction

  function automatic bit v4_finish();
    if (v4_val > 255) begin
      v4_mode = V4_FAIL;
      return 0;
    end
    v4_word = (v4_word << 8) | v4_val[7:0];
    v4_mode = V4_OK;
    return 1;
  endfunction

  function automatic int v4_feed(bit [7:0] c);
    if (v4_mode != V4_ACTIVE) return 0;
    if (c >= "0" && c <= "9") begin
      if (v4_dig >= 3) begin
        v4_mode = V4_FAIL;
        return 0;
      end
      v4_val = (v4_val * 10 + (c - "0")) & 16'hFFFF;
      v4_dig++;
      if (v4_dig == 3 && v4_oct == 3) return v4_finish() ? 2 : 0;
      return 0;
    end
    if (c == "." && v4_dig >= 1 && v4_oct < 3) begin
      if (v4_val > 255) begin
        v4_mode = V4_FAIL;
        return 0;
      end
      v4_word = (v4_word << 8) | v4_val[7:0];
      v4_oct++;
      v4_dig = 0;
      v4_val = 0;
      return 0;
    end
    if (v4_dig >= 1 && v4_oct == 3) return v4_finish() ? 1 : 0;
    v4_mode = V4_FAIL;
    return 0;
  endfunction

  function automatic void v6_restart();
    v6_st = 0;
    foreach (v6_grp[i]) v6_grp[i] = 0;
  endfunction

  function automatic bit v6_feed(bit [7:0] c);
    int h;
    int unsigned g;
    if (v6_st >= 41) return 0;
    if (v6_st == 0) begin
      v6_st = (c == "[") ? 1 : 255;
      return 0;
    end
    if (v6_st == 40) begin
      v6_st = (c == "]") ? 41 : 255;
      return v6_st == 41;
    end
    if ((v6_st - 1) % 5 == 4) begin
      v6_st = (c == ":") ? v6_st + 1 : 255;
      return 0;
    end
    h = hex_of(c);
    g = ((v6_st - 1) / 5) & 7;
    if (h < 0) begin
      v6_st = 255;
      return 0;
    end
    v6_grp[g] = {v6_grp[g][11:0], h[3:0]};
    v6_st++;
    return 0;
  endfunction

  function automatic bit prefix_feed(bit [7:0] c);
    string txt;
    int unsigned m;
    m = pfx_st;
    if (m >= 6) return 0;
    if (m < 2) begin
      if (c == (m == 0 ? "i" : "p")) pfx_st = m + 1;
      else begin
        pfx_st = 7;
        allow = 7;
      end
      return 0;
    end
    if (m == 2) begin
      if (c == "c") allow = 4;
      else if (c == "6") allow = 2;
      else if (c == "4") allow = 1;
      else if (c == ":") allow = 3;
      else begin
        pfx_st = 7;
        allow = 7;
        return 0;
      end
    end
    case (allow)
      3'd4: txt = "ipc://";
      3'd2: txt = "ip6://";
      3'd1: txt = "ip4://";
      default: txt = "ip://";
    endcase
    if (c != txt[m]) begin
      pfx_st = 7;
      allow = 7;
      return 0;
    end
    if (m + 1 == txt.len()) begin
      pfx_st = 6;
      return 1;
    end
    pfx_st = m + 1;
    return 0;
  endfunction

  function automatic void string_restart();
    pos_cnt = 0;
    pfx_st = 0;
    allow = 0;
    v4_restart();
    v6_restart();
    track_set(0, TR_FRESH);
    track_set(1, TR_OFF);
    track_set(2, TR_OFF);
  endfunction

  // advance the parser by one byte; push the result on the last byte
  function automatic void parse_byte(esp_in_t it);
    int r4, t;
    int unsigned len;
    bit is4, is6;
    esp_out_t r;
    r = '0;
    r4 = v4_feed(it.ch);
    if (r4 == 1) track_set(1, TR_FRESH);
    for (int k = 0; k < 3; k++) track_feed(k, it.ch);
    if (r4 == 2) track_set(1, TR_FRESH);
    if (v6_feed(it.ch)) track_set(2, TR_FRESH);
    if (prefix_feed(it.ch)) begin
      v4_restart();
      v6_restart();
      track_set(0, TR_FRESH);
      track_set(1, TR_OFF);
      track_set(2, TR_OFF);
    end
    if (pos_cnt <= MaxChars) pos_cnt++;
    if (!it.last) return;
    if (pfx_st < 6) allow = 7;
    len = clamp_len(pos_cnt);
    is4 = 0;
    if (allow[0]) begin
      if (v4_mode == V4_OK) begin
        is4 = 1;
        r.ip4_address = v4_word;
      end else if (v4_mode == V4_ACTIVE && v4_oct == 3 && v4_dig >= 1 && v4_val <= 255) begin
        is4 = 1;
        r.ip4_address = (v4_word << 8) | v4_val[7:0];
      end
    end
    is6 = !is4 && allow[1] && v6_st == 41;
    if (is6) begin
      r.scope = ScopeIp6;
      t = 2;
      r.ip6_high = {v6_grp[0], v6_grp[1], v6_grp[2], v6_grp[3]};
      r.ip6_low = {v6_grp[4], v6_grp[5], v6_grp[6], v6_grp[7]};
    end else if (is4) begin
      r.scope = ScopeIp4;
      t = 1;
    end else begin
      t = 0;
      if (allow[1:0] == 2'b11) r.scope = ScopeName;
      else if (allow[1]) r.scope = ScopeIp6Name;
      else if (allow[0]) r.scope = ScopeIp4Name;
      else if (allow[2]) r.scope = ScopeIpc;
      else r.scope = ScopeNull;
    end
    if (trk_phase[t] == TR_OFF || trk_phase[t] == TR_FRESH || trk_empty[t]) begin
      r.name_offset = len;
      r.name_length = 0;
    end else begin
      r.name_offset = trk_start[t];
      r.name_length = trk_len[t];
    end
    if (trk_phase[t] == TR_DIGITS || (trk_phase[t] == TR_DONE && prt_ok[t])) begin
      r.port_found = 1;
      r.port = prt_val[t][15:0];
    end
    r.too_long = pos_cnt > MaxChars;
    parse_q.push_back(r);
    string_restart();
  endfunction

  function automatic void push_text(string s);
    esp_in_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.ch = s[i];
      it.last = (i == s.len() - 1);
      byte_q.push_back(it);
    end
  endfunction

  function automatic string rand_piece();
    string s;
    case ($urandom_range(0, 9))
      0: s = "ipc://";
      1: s = "ip6://";
      2: s = "ip4://";
      3: s = "ip://";
      4: s = ":";
      5: s = ".";
      6: s = "[";
      7: s = "]";
      8: s = $sformatf("%0d", $urandom_range(0, 300));
      default: s = $sformatf("%c", $urandom_range(0, 255));
    endcase
    return s;
  endfunction

  function automatic string rand_endpoint();
    string s, p;
    case ($urandom_range(0, 5))
      0: p = "";
      1: p = "ipc://";
      2: p = "ip6://";
      3: p = "ip4://";
      4: p = "ip://";
      default: p = rand_piece();
    endcase
    s = p;
    case ($urandom_range(0, 3))
      0: s = {s, $sformatf("%0d.%0d.%0d.%0d", $urandom_range(0, 260), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 999))};
      1: begin
        s = {s, "["};
        for (int g = 0; g < 8; g++)
          s = {s, ($urandom_range(0, 1) ? $sformatf("%04x", $urandom_range(0, 65535))
                                        : $sformatf("%04X", $urandom_range(0, 65535))),
               (g < 7 ? ":" : "]")};
      end
      2: s = {s, "host", $sformatf("%0d", $urandom_range(0, 99))};
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: s = {s, ":", $sformatf("%0d", $urandom())};
      1: s = {s, ":", $sformatf("%0d", $urandom_range(0, 65535)), rand_piece()};
      2: s = {s, ":99999999999"};
      default: ;
    endcase
    if ($urandom_range(0, 4) == 0)
      for (int i = $urandom_range(0, 3); i > 0; i--) s = {s, rand_piece()};
    // occasional mutation of one byte
    if ($urandom_range(0, 5) == 0 && s.len() > 0)
      s[$urandom_range(0, s.len() - 1)] = $urandom_range(0, 255);
    if (s.len() == 0) s = "x";
    return s;
  endfunction

  initial begin
    esp_in_t it;
    string_restart();
    // directed
    push_text("ip4://255.255.255.255:65535");
    push_text("ip6://[0123:4567:89ab:cdef:ABCD:EF01:2345:6789]:80x");
    push_text("ipc://endpoint");
    push_text("ip://1.2.3.4:4294967295");
    push_text("ip://host:4294967296");
    push_text("10.0.0.1");
    push_text("256.1.1.1:7");
    push_text("1.2.3.4567");
    push_text("[1:2:3:4:5:6:7:8]");
    push_text("ip4://[0000:0000:0000:0000:0000:0000:0000:0001]");
    push_text("ip6://1.2.3.4");
    push_text(":123");
    push_text("::");
    push_text("ip");
    push_text("ipc:/");
    push_text("a");
    for (int i = 0; i < 1030; i++) begin
      it.ch = (i % 7 == 0) ? 8'h00 : 8'hFF;
      it.last = (i == 1029);
      byte_q.push_back(it);
    end
    for (int i = 0; i < 8; i++) begin
      it.ch = 8'(1 << i);
      it.last = 1;
      byte_q.push_back(it);
    end
    // random strings
    for (int n = 0; n < 2; n++) push_text(rand_endpoint());
  end

  // driver
  int  burst_left, gap_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        parse_byte(in_data);
        accepted_in <= accepted_in + 1;
      end
      if (byte_q.size() < 40 && !stim_done && accepted_in < ItemTarget)
        push_text(rand_endpoint());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= byte_q.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
        end else burst_left <= burst_left - 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern with one long hold-off
  int hold_cnt, cyc;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
      cyc <= 0;
    end else begin
      cyc <= cyc + 1;
      if (cyc == 150) hold_cnt <= 400;
      else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
      if (hold_cnt > 0 || cyc == 150) out_ready <= 1'b0;
      else if ((cyc / 500) % 2 == 0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    esp_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (parse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = parse_q.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data);
        end
      end
    end
  end

  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("tb_endpoint_string_parser_core: FAIL");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    accepted_in = 0;
    stim_done = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (accepted_in >= ItemTarget);
    stim_done = 1;
    wait (byte_q.size() == 0 && !in_valid);
    wait (parse_q.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && parse_q.size() == 0) $display("tb_endpoint_string_parser_core: PASS");
    else $display("tb_endpoint_string_parser_core: FAIL");
    $finish;
  end

endmodule
